// ===== sv/sha_md_pkg.sv =====
// sha-256 digest package: state type, control structs, round constants, initial hash words
// no dependencies; used by every module of the digest block
`timescale 1ns / 1ps
`default_nettype none

package sha_md_pkg;

    typedef logic [31:0] t_word;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_ADD,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_OUT
    } t_state;

    // block/schedule window controls
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
    } t_sched_ctl;

    // round unit controls
    typedef struct packed {
        logic load_iv;
        logic init;
        logic round;
        logic add;
        logic rotate;
    } t_core_ctl;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam t_word HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

// ===== sv/sha256_message_digest.sv =====
// sha-256 message digest top level: sequencer, byte and length counters, padding
// depends on sha_md_pkg, sha_md_sched, sha_md_core
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready   | i_data_byte, i_byte_valid, i_end_of_message
// out      | o_out_valid / i_out_ready | o_digest_word, o_word_index, o_final_word
//
// the 64th byte of a block starts a compression (load, 64 rounds of the shared round
// unit, hash add) with o_in_ready low. an end item pads one byte per cycle, pausing
// at the length field and compressing each padded block, then offers the eight
// digest words, one per out transfer, h0 first.
// o_in_ready stays low until the eighth word is taken; a stalled output holds.
// reset (synchronous, active low) loads the initial hash and clears all counters.

module sha256_message_digest (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_byte_valid,
    input  wire         i_end_of_message,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);

    sha_md_pkg::t_state     r_state;
    sha_md_pkg::t_state     n_state;
    logic [5:0]             r_pos;
    logic [60:0]            r_count;
    logic [5:0]             r_round;
    logic [2:0]             r_widx;
    logic                   r_end;
    logic                   r_sent80;
    logic                   r_fin;

    logic                   in_xfer;
    logic                   out_xfer;
    logic [63:0]            bit_len;
    logic [7:0]             len_byte;
    sha_md_pkg::t_sched_ctl sched_ctl;
    sha_md_pkg::t_core_ctl  core_ctl;
    sha_md_pkg::t_word      sched_w;
    sha_md_pkg::t_word      digest;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // length bytes, most significant first, picked by position 56..63
    assign bit_len  = {r_count, 3'b000};
    assign len_byte = bit_len[{3'd7 - r_pos[2:0], 3'b000} +: 8];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_md_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_byte_valid && r_pos == sha_md_pkg::LAST_POS) begin
                        n_state = sha_md_pkg::ST_INIT;
                    end else if (i_end_of_message) begin
                        n_state = sha_md_pkg::ST_PAD80;
                    end
                end
            end
            sha_md_pkg::ST_INIT: begin
                n_state = sha_md_pkg::ST_ROUND;
            end
            sha_md_pkg::ST_ROUND: begin
                if (r_round == sha_md_pkg::LAST_ROUND) begin
                    n_state = sha_md_pkg::ST_ADD;
                end
            end
            sha_md_pkg::ST_ADD: begin
                priority if (r_fin) begin
                    n_state = sha_md_pkg::ST_OUT;
                end else if (r_end && r_sent80) begin
                    n_state = sha_md_pkg::ST_PADZ;
                end else if (r_end) begin
                    n_state = sha_md_pkg::ST_PAD80;
                end else begin
                    n_state = sha_md_pkg::ST_IDLE;
                end
            end
            sha_md_pkg::ST_PAD80: begin
                if (r_pos == sha_md_pkg::LAST_POS) begin
                    n_state = sha_md_pkg::ST_INIT;
                end else begin
                    n_state = sha_md_pkg::ST_PADZ;
                end
            end
            sha_md_pkg::ST_PADZ: begin
                if (r_pos == sha_md_pkg::LEN_POS) begin
                    n_state = sha_md_pkg::ST_LEN;
                end else if (r_pos == sha_md_pkg::LAST_POS) begin
                    n_state = sha_md_pkg::ST_INIT;
                end
            end
            sha_md_pkg::ST_LEN: begin
                if (r_pos == sha_md_pkg::LAST_POS) begin
                    n_state = sha_md_pkg::ST_INIT;
                end
            end
            sha_md_pkg::ST_OUT: begin
                if (out_xfer && r_widx == sha_md_pkg::LAST_WORD) begin
                    n_state = sha_md_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha_md_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready          = 1'b0;
        o_out_valid         = 1'b0;
        sched_ctl.push      = 1'b0;
        sched_ctl.push_byte = sha_md_pkg::ZERO_BYTE;
        sched_ctl.step      = 1'b0;
        core_ctl.load_iv    = 1'b0;
        core_ctl.init       = 1'b0;
        core_ctl.round      = 1'b0;
        core_ctl.add        = 1'b0;
        core_ctl.rotate     = 1'b0;
        unique case (r_state)
            sha_md_pkg::ST_IDLE: begin
                o_in_ready          = 1'b1;
                sched_ctl.push      = in_xfer && i_byte_valid;
                sched_ctl.push_byte = i_data_byte;
            end
            sha_md_pkg::ST_INIT: begin
                core_ctl.init = 1'b1;
            end
            sha_md_pkg::ST_ROUND: begin
                core_ctl.round = 1'b1;
                sched_ctl.step = 1'b1;
            end
            sha_md_pkg::ST_ADD: begin
                core_ctl.add = 1'b1;
            end
            sha_md_pkg::ST_PAD80: begin
                sched_ctl.push      = 1'b1;
                sched_ctl.push_byte = sha_md_pkg::PAD_BYTE;
            end
            sha_md_pkg::ST_PADZ: begin
                sched_ctl.push = (r_pos != sha_md_pkg::LEN_POS);
            end
            sha_md_pkg::ST_LEN: begin
                sched_ctl.push      = 1'b1;
                sched_ctl.push_byte = len_byte;
            end
            sha_md_pkg::ST_OUT: begin
                o_out_valid      = 1'b1;
                core_ctl.rotate  = out_xfer;
                core_ctl.load_iv = out_xfer && (r_widx == sha_md_pkg::LAST_WORD);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // state, counters and message flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_md_pkg::ST_IDLE;
            r_pos    <= '0;
            r_count  <= '0;
            r_round  <= '0;
            r_widx   <= '0;
            r_end    <= 1'b0;
            r_sent80 <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sched_ctl.push) begin
                r_pos <= r_pos + 6'd1;
            end
            if (in_xfer && i_byte_valid) begin
                r_count <= r_count + 61'd1;
            end
            if (in_xfer && i_end_of_message) begin
                r_end <= 1'b1;
            end
            if (r_state == sha_md_pkg::ST_PAD80) begin
                r_sent80 <= 1'b1;
            end
            if (r_state == sha_md_pkg::ST_LEN && r_pos == sha_md_pkg::LAST_POS) begin
                r_fin <= 1'b1;
            end
            if (core_ctl.round) begin
                r_round <= r_round + 6'd1;
            end
            if (out_xfer) begin
                r_widx <= r_widx + 3'd1;
            end
            // last digest word taken: ready for the next message
            if (core_ctl.load_iv) begin
                r_count  <= '0;
                r_end    <= 1'b0;
                r_sent80 <= 1'b0;
                r_fin    <= 1'b0;
            end
        end
    end

    sha_md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (sched_w)
    );

    sha_md_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_k      (sha_md_pkg::ROUND_K[r_round]),
        .i_w      (sched_w),
        .o_digest (digest)
    );

    // digest word and index come straight from registers; the final flag is decoded from the index
    assign o_digest_word = digest;
    assign o_word_index  = r_widx;
    assign o_final_word  = (r_widx == sha_md_pkg::LAST_WORD);

endmodule

`default_nettype wire

// ===== sv/sha_md_sched.sv =====
// sha-256 block buffer and message schedule window in one 512-bit shift line
// depends on sha_md_pkg (t_word, t_sched_ctl)
`timescale 1ns / 1ps
`default_nettype none

module sha_md_sched (
    input  wire                     i_clk,
    input  sha_md_pkg::t_sched_ctl  i_ctl,
    output sha_md_pkg::t_word       o_w
);

    // word j of the window is w[t + j] while rounds run
    logic [511:0]      r_blk;
    sha_md_pkg::t_word w0;
    sha_md_pkg::t_word w1;
    sha_md_pkg::t_word w9;
    sha_md_pkg::t_word w14;
    sha_md_pkg::t_word sig0;
    sha_md_pkg::t_word sig1;
    sha_md_pkg::t_word w_new;

    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];

    // next schedule word
    assign sig0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign sig1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
    assign w_new = w0 + sig0 + w9 + sig1;

    // bytes enter big-endian; rounds shift whole words
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_blk <= {r_blk[503:0], i_ctl.push_byte};
        end else if (i_ctl.step) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

    assign o_w = w0;

endmodule

`default_nettype wire

// ===== sv/sha_md_core.sv =====
// sha-256 round unit: working variables a..h, one round per cycle, and the hash words
// depends on sha_md_pkg (t_word, t_core_ctl, HASH_IV)
`timescale 1ns / 1ps
`default_nettype none

module sha_md_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sha_md_pkg::t_core_ctl   i_ctl,
    input  sha_md_pkg::t_word       i_k,
    input  sha_md_pkg::t_word       i_w,
    output sha_md_pkg::t_word       o_digest
);

    sha_md_pkg::t_word r_h [8];
    sha_md_pkg::t_word r_v [8];
    sha_md_pkg::t_word big0;
    sha_md_pkg::t_word big1;
    sha_md_pkg::t_word ch;
    sha_md_pkg::t_word maj;
    sha_md_pkg::t_word t1;
    sha_md_pkg::t_word t2;

    // round function
    assign big1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
                ^ {r_v[4][24:0], r_v[4][31:25]};
    assign big0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
                ^ {r_v[0][21:0], r_v[0][31:22]};
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1   = r_v[7] + big1 + ch + i_k + i_w;
    assign t2   = big0 + maj;

    // hash words: initial value, block add, rotate out during readout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.load_iv) begin
            r_h <= sha_md_pkg::HASH_IV;
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < 7; i++) begin
                r_h[i] <= r_h[i + 1];
            end
            r_h[7] <= r_h[0];
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_v <= r_h;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_digest = r_h[0];

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for sha256_message_digest: byte items in, eight digest words out
// depends only on the rtl top level; carries its own sha-256 model and constant tables

module tb_top;

    localparam int     CLK_HALF     = 5;
    localparam int     ITEM_TARGET  = 310;
    localparam int     DRAIN_CYCLES = 300;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     HOLD_AFTER   = 60;
    localparam int     BUSY_PCT     = 86;
    localparam int     LIGHT_PCT    = 12;
    localparam int     NOISE_PCT    = 8;
    localparam longint TIMEOUT_NS   = 3_000_000;

    // message lengths around the padding and block boundaries
    localparam int PAD_EDGE_LEN [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        int         gap_pct;
        int         stall_pct;
    } t_msg_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_flag;
    } t_digest_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_msg = 1'b0;
    logic        out_ready  = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] digest_word;
    wire  [2:0]  word_index;
    wire         final_word;

    t_msg_item    byte_items [$];
    t_msg_item    cur_item;
    t_digest_word pending_digest [$];

    int n_sent     = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int fail_count = 0;

    // model state: chaining value, current block, bytes taken so far
    logic [31:0] hash_acc [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    sha256_message_digest u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_byte_valid     (byte_valid),
        .i_end_of_message (end_of_msg),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_digest_word    (digest_word),
        .o_word_index     (word_index),
        .o_final_word     (final_word)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_digest_state();
        for (int i = 0; i < 8; i++) hash_acc[i] = SHA_IV[i];
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        msg_bytes = '0;
    endfunction

    // 64 rounds over msg_block, folded into hash_acc
    function automatic void mix_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_acc[0]; b = hash_acc[1]; c = hash_acc[2]; d = hash_acc[3];
        e = hash_acc[4]; f = hash_acc[5]; g = hash_acc[6]; h = hash_acc[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
        hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
    endfunction

    // feed one transferred item; an end item pads, finishes and queues the digest
    function automatic void absorb_item(input t_msg_item it);
        int           pos;
        logic [63:0]  bit_len;
        t_digest_word dw;
        if (it.has_byte) begin
            msg_block[int'(msg_bytes[5:0])] = it.data;
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0)
                mix_block();
        end
        if (!it.last)
            return;
        pos = int'(msg_bytes[5:0]);
        msg_block[pos] = 8'h80;
        pos++;
        // no room for the length: close this block and start another
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            mix_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++)
            msg_block[56 + i] = bit_len[63 - 8*i -: 8];
        mix_block();
        for (int i = 0; i < 8; i++) begin
            dw = '{hash_acc[i], 3'(i), i == 7};
            pending_digest = {pending_digest, dw};
        end
        clear_digest_state();
    endfunction

    function automatic void add_item(input logic [7:0] d, input logic v, input logic e,
                                     input int gap, input int stall);
        t_msg_item it;
        it = '{d, v, e, gap, stall};
        byte_items = {byte_items, it};
    endfunction

    // one message with random bytes and scattered empty items; returns counted items
    function automatic int queue_message(input int len, input int gap, input int stall);
        int n;
        bit end_on_byte;
        n = 0;
        end_on_byte = (len != 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < NOISE_PCT) begin
                add_item(8'($urandom_range(255)), 1'b0, 1'b0, gap, stall);
                n++;
            end
            add_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1), gap, stall);
            n++;
        end
        if (!end_on_byte) begin
            add_item(8'($urandom_range(255)), 1'b0, 1'b1, gap, stall);
            n++;
        end
        return n;
    endfunction

    // driver: offer items from the queue, feed the model on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_item(cur_item);
                n_sent    <= n_sent + 1;
                stall_pct <= cur_item.stall_pct;
            end
            if (!in_valid || in_ready) begin
                if (byte_items.size() != 0 &&
                    (hold_left != 0 || $urandom_range(99) >= byte_items[0].gap_pct)) begin
                    cur_item = byte_items.pop_front();
                    data_byte  <= cur_item.data;
                    byte_valid <= cur_item.has_byte;
                    end_of_msg <= cur_item.last;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long output hold while a digest waits, so the input backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && out_valid && n_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor: compare each transferred word with the oldest expected one
    always @(posedge i_clk) begin : digest_check
        t_digest_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (pending_digest.size() == 0) begin
                    $display("%0t: unexpected digest word %h index %0d", $time,
                             digest_word, word_index);
                    fail_count++;
                end else begin
                    want = pending_digest.pop_front();
                    if (digest_word !== want.word) begin
                        $display("%0t: digest word: expected %h, got %h", $time,
                                 want.word, digest_word);
                        fail_count++;
                    end
                    if (word_index !== want.index) begin
                        $display("%0t: word index: expected %0d, got %0d", $time,
                                 want.index, word_index);
                        fail_count++;
                    end
                    if (final_word !== want.final_flag) begin
                        $display("%0t: final word flag: expected %b, got %b", $time,
                                 want.final_flag, final_word);
                        fail_count++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : stimulus
        int n_items;
        int msg_no;
        int len;
        int pick;
        int gap;
        int stall;
        clear_digest_state();

        // directed: empty message, lone bytes at both extremes, bare end after a byte,
        // ignored items inside a short message
        add_item(8'h5a, 1'b0, 1'b1, 0, 0);
        add_item(8'h00, 1'b1, 1'b1, 0, 0);
        add_item(8'hff, 1'b1, 1'b0, 0, 0);
        add_item(8'ha5, 1'b0, 1'b1, 0, 0);
        add_item(8'h3c, 1'b0, 1'b0, 0, 0);
        add_item(8'h61, 1'b1, 1'b0, 0, 0);
        add_item(8'hc3, 1'b0, 1'b0, 0, 0);
        add_item(8'h62, 1'b1, 1'b0, 0, 0);
        add_item(8'h63, 1'b1, 1'b1, 0, 0);
        n_items = 9;

        // random messages, idling pattern rotating per message
        msg_no = 0;
        while (n_items < ITEM_TARGET) begin
            case (msg_no % 4)
                0: begin gap = 0;         stall = 0;         end
                1: begin gap = BUSY_PCT;  stall = 0;         end
                2: begin gap = 0;         stall = BUSY_PCT;  end
                default: begin gap = LIGHT_PCT; stall = LIGHT_PCT; end
            endcase
            pick = $urandom_range(9);
            if (pick < 5)
                len = $urandom_range(12);
            else if (pick < 8)
                len = PAD_EDGE_LEN[$urandom_range(9)];
            else
                len = $urandom_range(130, 13);
            n_items += queue_message(len, gap, stall);
            msg_no++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_items.size() != 0 || in_valid) @(posedge i_clk);
        while (pending_digest.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sha_md_pkg.sv
sv/sha_md_sched.sv
sv/sha_md_core.sv
sv/sha256_message_digest.sv
test/tb_top.sv
